>>> rtl/gta_pkg.sv
package gta_pkg;

  localparam int ELEM_BITS  = 16;
  localparam int ACC_BITS   = 48;
  localparam int TILE_DIM   = 4;
  localparam int TILE_CELLS = TILE_DIM * TILE_DIM;
  localparam int PROD_BITS  = 2 * ELEM_BITS;
  localparam int IDX_BITS   = $clog2(TILE_DIM);
  localparam int CNT_BITS   = $clog2(TILE_CELLS);

  typedef logic signed [ELEM_BITS-1:0] elem_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [ACC_BITS-1:0]  acc_t;

  typedef struct packed {
    elem_t a_row0;
    elem_t a_row1;
    elem_t a_row2;
    elem_t a_row3;
    elem_t b_col0;
    elem_t b_col1;
    elem_t b_col2;
    elem_t b_col3;
    logic  clear_first;
    logic  last_step;
  } step_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] tile_row;
    logic [IDX_BITS-1:0] tile_col;
    acc_t                tile_sum;
    logic                tile_done;
  } tile_t;

  // Control shared by every cell of the chain.
  typedef struct packed {
    logic mul_en;
    logic add_en;
    logic clear;
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

>>> rtl/gemm_tile_4x4_accumulator.sv
// Channel  Direction  Handshake               Payload
// step     in         step_valid/step_stall   step_t: A column, B row, clear, last
// tile     out        tile_valid/tile_stall   tile_t: row, column, sum, done
//
// One k step is taken per cycle while step_stall is low. Products register at
// the accepting edge; in the cycle after, the sixteen accumulators update and the
// drain registers load the finished sums, raising tile_valid. The drain chain then
// offers 16 beats in row-major order, one per cycle while tile_stall is low.
// A step with last_step set stalls while an earlier last step is still in the
// product stage or its tile is still draining; other steps stall only in reset.
// Reset (rst, synchronous) zeroes the accumulators and empties both stages.
module gemm_tile_4x4_accumulator
  import gta_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  step_valid,
  output logic  step_stall,
  input  step_t step,
  output logic  tile_valid,
  input  logic  tile_stall,
  output tile_t tile
);

  logic                step_take;
  logic                tile_take;
  logic                s1_valid;
  logic                s1_clear;
  logic                s1_last;
  logic [CNT_BITS-1:0] cnt;
  cell_ctrl_t          ctrl;
  elem_t               a_vec [TILE_DIM];
  elem_t               b_vec [TILE_DIM];
  acc_t                drain [TILE_CELLS];

  assign step_stall = rst | (step.last_step & ((s1_valid & s1_last) | tile_valid));
  assign step_take  = step_valid & ~step_stall;
  assign tile_take  = tile_valid & ~tile_stall;

  assign a_vec[0] = step.a_row0;
  assign a_vec[1] = step.a_row1;
  assign a_vec[2] = step.a_row2;
  assign a_vec[3] = step.a_row3;
  assign b_vec[0] = step.b_col0;
  assign b_vec[1] = step.b_col1;
  assign b_vec[2] = step.b_col2;
  assign b_vec[3] = step.b_col3;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= step_take;
    end
  end

  always_ff @(posedge clk) begin
    if (step_take) begin
      s1_clear <= step.clear_first;
      s1_last  <= step.last_step;
    end
  end

  always_comb begin
    ctrl.mul_en = step_take;
    ctrl.add_en = s1_valid;
    ctrl.clear  = s1_clear;
    ctrl.load   = s1_valid & s1_last;
    ctrl.shift  = tile_take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_valid <= 1'b0;
      cnt        <= '0;
    end else if (ctrl.load) begin
      tile_valid <= 1'b1;
      cnt        <= '0;
    end else if (tile_take) begin
      if (cnt == CNT_BITS'(TILE_CELLS - 1)) begin
        tile_valid <= 1'b0;
      end
      cnt <= cnt + 1'b1;
    end
  end

  for (genvar r = 0; r < TILE_DIM; r++) begin : g_row
    for (genvar c = 0; c < TILE_DIM; c++) begin : g_col
      localparam int IDX = r * TILE_DIM + c;
      acc_t shift_in;

      if (IDX == TILE_CELLS - 1) begin : g_tail
        assign shift_in = '0;
      end else begin : g_link
        assign shift_in = drain[IDX+1];
      end

      gta_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .a        (a_vec[r]),
        .b        (b_vec[c]),
        .shift_in (shift_in),
        .drain    (drain[IDX])
      );
    end
  end

  always_comb begin
    tile.tile_row  = cnt[CNT_BITS-1:IDX_BITS];
    tile.tile_col  = cnt[IDX_BITS-1:0];
    tile.tile_sum  = drain[0];
    tile.tile_done = (cnt == CNT_BITS'(TILE_CELLS - 1));
  end

endmodule

>>> rtl/gta_cell.sv
module gta_cell
  import gta_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  elem_t      a,
  input  elem_t      b,
  input  acc_t       shift_in,
  output acc_t       drain
);

  localparam int SUM_BITS = ((ACC_BITS > PROD_BITS) ? ACC_BITS : PROD_BITS) + 1;
  localparam logic signed [SUM_BITS-1:0] SAT_MAX =
    {{(SUM_BITS-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SAT_MIN = ~SAT_MAX;

  prod_t                      prod;
  acc_t                       acc;
  acc_t                       acc_base;
  acc_t                       acc_next;
  logic signed [SUM_BITS-1:0] sum;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= a * b;
    end
  end

  always_comb begin
    acc_base = ctrl.clear ? '0 : acc;
    sum      = SUM_BITS'(acc_base) + SUM_BITS'(prod);
    if (sum > SAT_MAX) begin
      acc_next = SAT_MAX[ACC_BITS-1:0];
    end else if (sum < SAT_MIN) begin
      acc_next = SAT_MIN[ACC_BITS-1:0];
    end else begin
      acc_next = sum[ACC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctrl.add_en) begin
      acc <= acc_next;
    end
  end

  // The drain register snapshots the finished sum and then moves one place
  // toward the head of the chain on every output beat.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      drain <= acc_next;
    end else if (ctrl.shift) begin
      drain <= shift_in;
    end
  end

endmodule
